// ----- design/euler_to_quaternion_deg_unit_macros.svh -----
// Assertion macros for the Euler-to-quaternion design.
// Used by the top level; no other dependencies.
`ifndef EULER_TO_QUATERNION_DEG_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_DEG_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define E2Q_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define E2Q_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/e2q_pkg.sv -----
// Package for the Euler-to-quaternion unit: widths, constants and the atan table.
// No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int ANG_W = 32;
    localparam int OUT_W = 18;
    localparam int CW = 34;   // Q2.30 datapath with headroom
    localparam logic signed [34:0] DEG_FULL = 35'sd23592960;
    localparam logic signed [34:0] H90 = 35'sd11796480;
    localparam logic signed [34:0] H180 = 35'sd23592960;
    localparam logic [26:0] DEG2RAD = 27'd74961321;
    localparam logic signed [CW-1:0] GAIN = 34'sd652032874;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
        logic negc;
    } cstate_t;

    function automatic cval_t atan_q30(input int i);
        cval_t t;
        unique case (i)
            0: t = 34'sd843314857;
            1: t = 34'sd497837829;
            2: t = 34'sd263043837;
            3: t = 34'sd133525159;
            4: t = 34'sd67021687;
            5: t = 34'sd33543516;
            6: t = 34'sd16775851;
            7: t = 34'sd8388437;
            8: t = 34'sd4194283;
            9: t = 34'sd2097149;
            default: t = (i < 31) ? cval_t'(34'sd1 <<< (30 - i)) : '0;
        endcase
        return t;
    endfunction
endpackage

// ----- design/e2q_reduce.sv -----
// Angle reduction cell: remainder by 360, halving, fold and scaling to radians.
// Depends on e2q_pkg. Two register stages.
`timescale 1ns / 1ps
module e2q_reduce
    import e2q_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] ang,
    output cstate_t                 st
);
    // Remainder by 360<<16: the quotient is at most 91, so a reciprocal multiply
    // estimates it and one correction step fixes it.
    logic [31:0] mag;
    logic        neg_a;
    logic [7:0]  q_est;
    logic [39:0] prod;
    logic [34:0] rem0;
    logic [34:0] rem1;
    logic signed [34:0] h_reg, h_next;
    logic signed [34:0] hf;
    logic        negc;
    logic [33:0] hm;
    logic [61:0] rad;
    logic [42:0] rad_r;
    cval_t       z;

    always_comb
    begin
        neg_a = ang[ANG_W-1];
        mag   = neg_a ? 32'(-ang) : 32'(ang);
        // floor(mag / 23592960) via mag * 182 >> 32 (underestimates by at most 1)
        prod  = 40'(mag) * 40'd182;
        q_est = prod[39:32];
        rem0  = 35'(mag) - 35'(q_est) * 35'd23592960;
        rem1  = (rem0 >= 35'(DEG_FULL)) ? rem0 - 35'(DEG_FULL) : rem0;
        h_next = neg_a ? -$signed(rem1) : $signed(rem1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg <= h_next;
        end
    end

    always_comb
    begin
        negc = 1'b0;
        hf   = h_reg;
        if (h_reg > H90)
        begin
            hf   = H180 - h_reg;
            negc = 1'b1;
        end
        else if (h_reg < -H90)
        begin
            hf   = -H180 - h_reg;
            negc = 1'b1;
        end
        hm    = hf[34] ? 34'(-hf) : 34'(hf);
        rad   = 62'(hm) * 62'(DEG2RAD);
        rad_r = 43'((rad + 62'd262144) >> 19);
        z     = hf[34] ? -cval_t'(rad_r) : cval_t'(rad_r);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st.x    <= GAIN;
            st.y    <= '0;
            st.z    <= z;
            st.negc <= negc;
        end
    end
endmodule

// ----- design/e2q_cordic_cell.sv -----
// One rotation-mode CORDIC cell; the shift amount and angle come from the stage index.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_cordic_cell
    import e2q_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cstate_t din,
    output cstate_t dout
);
    localparam cval_t ATAN = atan_q30(IDX);
    cstate_t nx;
    cval_t   dx, dy;

    always_comb
    begin
        dx = din.y >>> IDX;
        dy = din.x >>> IDX;
        nx.negc = din.negc;
        if (!din.z[CW-1])
        begin
            nx.x = din.x - dx;
            nx.y = din.y + dy;
            nx.z = din.z - ATAN;
        end
        else
        begin
            nx.x = din.x + dx;
            nx.y = din.y - dy;
            nx.z = din.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout <= nx;
        end
    end
endmodule

// ----- design/e2q_combine.sv -----
// Quaternion combine: three-way products, sums, rounding and saturation.
// Depends on e2q_pkg. Three register stages.
`timescale 1ns / 1ps
module e2q_combine
    import e2q_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    en,
    input  cval_t                   sp, cp, sy, cy, sr, cr,
    output logic signed [OUT_W-1:0] qx, qy, qz, qw
);
    localparam int SH = 60 - OUT_FRAC_BITS;

    // Pair products rounded to Q2.30.
    function automatic cval_t rnd30(input logic signed [67:0] v);
        logic [67:0] m;
        m = v[67] ? 68'(-v) : 68'(v);
        m = (m + (68'd1 << 29)) >> 30;
        return v[67] ? -cval_t'(m) : cval_t'(m);
    endfunction

    function automatic logic signed [OUT_W-1:0] fin(input logic signed [69:0] v);
        logic [69:0] m;
        logic signed [70:0] r;
        m = v[69] ? 70'(-v) : 70'(v);
        m = (m + (70'd1 << (SH - 1))) >> SH;
        r = v[69] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (r > 71'(OUT_MAX))
        begin
            return OUT_MAX;
        end
        if (r < 71'(OUT_MIN))
        begin
            return OUT_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

    cval_t crsp_reg, srcp_reg, crcp_reg, srsp_reg;
    cval_t sy_reg, cy_reg;
    logic signed [67:0] p [8];
    logic signed [67:0] p_reg [8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crsp_reg <= rnd30(68'(cr) * 68'(sp));
            srcp_reg <= rnd30(68'(sr) * 68'(cp));
            crcp_reg <= rnd30(68'(cr) * 68'(cp));
            srsp_reg <= rnd30(68'(sr) * 68'(sp));
            sy_reg   <= sy;
            cy_reg   <= cy;
        end
    end

    always_comb
    begin
        p[0] = 68'(crsp_reg) * 68'(sy_reg);
        p[1] = 68'(srcp_reg) * 68'(cy_reg);
        p[2] = 68'(crsp_reg) * 68'(cy_reg);
        p[3] = 68'(srcp_reg) * 68'(sy_reg);
        p[4] = 68'(crcp_reg) * 68'(sy_reg);
        p[5] = 68'(srsp_reg) * 68'(cy_reg);
        p[6] = 68'(crcp_reg) * 68'(cy_reg);
        p[7] = 68'(srsp_reg) * 68'(sy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx <= fin(70'(p_reg[0]) - 70'(p_reg[1]));
            qy <= fin(-70'(p_reg[2]) - 70'(p_reg[3]));
            qz <= fin(70'(p_reg[4]) - 70'(p_reg[5]));
            qw <= fin(70'(p_reg[6]) + 70'(p_reg[7]));
        end
    end
endmodule

// ----- design/euler_to_quaternion_deg_unit.sv -----
// Euler angles (Q16.16 degrees) to a Q2.16 quaternion: one item per clock cycle
// when not stalled, through the reduction cells, the row of CORDIC cells and the
// product stages. The whole pipeline advances only when its last stage may move,
// so back-pressure stalls every stage together. Depends on e2q_pkg and the macro header.
`timescale 1ns / 1ps
`include "euler_to_quaternion_deg_unit_macros.svh"
module euler_to_quaternion_deg_unit
    import e2q_pkg::*;
#(
    parameter int CORDIC_STAGES = 18,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ANG_W-1:0] pitch_deg,
    input  logic signed [ANG_W-1:0] yaw_deg,
    input  logic signed [ANG_W-1:0] roll_deg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] quat_x,
    output logic signed [OUT_W-1:0] quat_y,
    output logic signed [OUT_W-1:0] quat_z,
    output logic signed [OUT_W-1:0] quat_w
);
    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = NS + 5;

    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;
    cstate_t        chain [3][NS+1];
    cval_t          s [3];
    cval_t          c [3];

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    e2q_reduce u_red_p (.clk(clk), .en(en), .ang(pitch_deg), .st(chain[0][0]));
    e2q_reduce u_red_y (.clk(clk), .en(en), .ang(yaw_deg),   .st(chain[1][0]));
    e2q_reduce u_red_r (.clk(clk), .en(en), .ang(roll_deg),  .st(chain[2][0]));

    for (genvar a = 0; a < 3; a++)
    begin : g_ang
        for (genvar i = 0; i < NS; i++)
        begin : g_cell
            e2q_cordic_cell #(.IDX(i)) u_cell (
                .clk(clk), .en(en), .din(chain[a][i]), .dout(chain[a][i+1])
            );
        end
        assign s[a] = chain[a][NS].y;
        assign c[a] = chain[a][NS].negc ? -chain[a][NS].x : chain[a][NS].x;
    end

    e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
        .clk(clk), .en(en),
        .sp(s[0]), .cp(c[0]), .sy(s[1]), .cy(c[1]), .sr(s[2]), .cr(c[2]),
        .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w)
    );

    `E2Q_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(quat_w), "result changed while stalled")
    `E2Q_ASSERT_IMP(a_ready_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without output back-pressure")
    `E2Q_ASSERT_NXT(a_enter, clk, rst_n, in_valid && in_ready, vld_reg[0], "accepted item not tracked")
endmodule
